@@ sv/pidl_pkg.sv @@
// Package for the positional insert/delete list unit.
// Sizes, operation and status codes, and the command bus that runs along the cell row.
// No dependencies.
package pidl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell in the cycle a transaction is taken.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ sv/positional_insert_delete_list_unit.sv @@
// Top level of the positional insert/delete list: control, a row of storage cells and
// the result register. Depends on pidl_pkg, pidl_ctrl and pidl_cell.
//
//  channel | handshake               | fields
//  in      | in_valid / in_stall     | action, position, value
//  out     | out_valid / out_stall   | removed_value, status, count
//
// One transaction per cycle while in_stall is low: every cell compares its own index with
// the position and shifts in the same cycle, so the result is registered at acceptance.
// Reset clears the element count and the result valid; cell contents stay undefined.
// in_stall is raised while a result is held and the output side stalls.
module positional_insert_delete_list_unit import pidl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [1:0]               status,
  output logic [COUNT_W-1:0]       count
);

  logic              go;
  cell_cmd_t         cmd;
  status_t           op_status;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_left [CAPACITY];
  logic [DATA_W-1:0] cell_right[CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [DATA_W-1:0] removed_sel;
  logic [DATA_W-1:0] removed_q;
  status_t           status_q;
  logic [COUNT_W-1:0] count_q;

  assign in_stall = out_valid && out_stall;
  assign go       = in_valid && !in_stall;

  pidl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .action    (action),
    .position  (position),
    .value     (value),
    .cmd       (cmd),
    .op_status (op_status),
    .cnt       (cnt),
    .cnt_next  (cnt_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = '0;
    end else begin : g_mid_l
      assign cell_left[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign cell_right[i] = '0;
    end else begin : g_mid_r
      assign cell_right[i] = cell_data[i+1];
    end

    pidl_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .cmd   (cmd),
      .left  (cell_left[i]),
      .right (cell_right[i]),
      .data  (cell_data[i]),
      .hit   (cell_hit[i])
    );
  end

  // At most one cell hits, so an OR of gated entries selects it.
  always_comb begin
    removed_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      removed_sel = removed_sel | (cell_hit[k] ? cell_data[k] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      removed_q <= removed_sel;
      status_q  <= op_status;
      count_q   <= COUNT_W'(cnt_next);
    end
  end

  assign removed_value = removed_q;
  assign status        = status_q;
  assign count         = count_q;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(cnt) <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid)
    else $error("accepted transaction produced no result");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    go && (op_status == ST_FULL) |-> CMP_W'(cnt) == CMP_W'(CAPACITY))
    else $error("full status with room left");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    go && (op_status != ST_DONE) |=> cnt == $past(cnt))
    else $error("failed operation changed the count");

endmodule

@@ sv/pidl_cell.sv @@
// One storage cell of the list row: holds one entry and shifts to/from its neighbors.
// Depends on pidl_pkg.
module pidl_cell import pidl_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] data,
  output logic              hit
);

  // Insert: cells past the slot take the left neighbor, the slot takes the new value.
  // Delete: the removed cell and those behind it take the right neighbor.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (idx > cmd.at) begin
        data <= left;
      end else if (idx == cmd.at) begin
        data <= cmd.value;
      end
    end else if (cmd.del && (idx >= cmd.at)) begin
      data <= right;
    end
  end

  assign hit = cmd.del && (idx == cmd.at);

endmodule

@@ sv/pidl_ctrl.sv @@
// Range checks, element count register and cell command generation.
// Depends on pidl_pkg.
module pidl_ctrl import pidl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic              action,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] value,
  output cell_cmd_t         cmd,
  output status_t           op_status,
  output logic [CNT_W-1:0]  cnt,
  output logic [CNT_W-1:0]  cnt_next
);

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             is_del;

  assign pos_x  = CMP_W'(position);
  assign cnt_x  = CMP_W'(cnt);
  assign is_del = (action == ACT_DELETE);

  always_comb begin
    op_status = ST_DONE;
    if (!is_del) begin
      if (pos_x > cnt_x) begin
        op_status = ST_RANGE;
      end else if (cnt_x == CMP_W'(CAPACITY)) begin
        op_status = ST_FULL;
      end
    end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
      op_status = ST_RANGE;
    end
  end

  always_comb begin
    cmd.ins   = go && !is_del && (op_status == ST_DONE);
    cmd.del   = go && is_del && (op_status == ST_DONE);
    // In range these fit the index width: insert pos < CAPACITY, delete pos-1 < count.
    cmd.at    = is_del ? IDX_W'(pos_x - CMP_W'(1)) : IDX_W'(pos_x);
    cmd.value = value;
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (cmd.del) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

@@ test/list_checker.sv @@
// Checker for the positional insert/delete list unit: watches both channels, keeps its own
// copy of the list, predicts each result and compares it field by field.
// Depends on pidl_pkg.
module list_checker import pidl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] removed_value,
  input  logic [1:0]               status,
  input  logic [COUNT_W-1:0]       count,
  output int                       errors,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0] removed;
    status_t                  stat;
    logic [COUNT_W-1:0]       cnt;
  } list_result_t;

  logic signed [DATA_W-1:0] list_image[$];   // front of list at index 0
  list_result_t             pending_results[$];
  int                       fail_count = 0;

  assign errors = fail_count;

  initial outstanding = 0;

  // Applies one operation to the list copy and returns the result it should produce.
  function automatic list_result_t apply_list_op(input action_t op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           p;
    p         = int'(pos);
    r.removed = '0;
    r.stat    = ST_DONE;
    if (op == ACT_INSERT) begin
      // range check wins over the full check
      if (p > list_image.size()) r.stat = ST_RANGE;
      else if (list_image.size() >= CAPACITY) r.stat = ST_FULL;
      else list_image.insert(p, val);
    end else begin
      if (p < 1 || p > list_image.size()) begin
        r.stat = ST_RANGE;
      end else begin
        r.removed = list_image[p - 1];
        list_image.delete(p - 1);
      end
    end
    r.cnt = COUNT_W'(list_image.size());
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_image.delete();
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: removed_value %0d status %0d count %0d",
                 removed_value, status, count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (removed_value !== want.removed) begin
            $error("removed_value: expected %0d, actual %0d", want.removed, removed_value);
            fail_count++;
          end
          if (status !== want.stat) begin
            $error("status: expected %0d, actual %0d", want.stat, status);
            fail_count++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, actual %0d", want.cnt, count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(apply_list_op(action_t'(action), position, value));
    end
    outstanding = pending_results.size();
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the positional insert/delete list unit: clock, reset, stimulus,
// output stalls and the verdict. Depends on pidl_pkg, the unit and list_checker.
module tb_top import pidl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 950;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ACT_INSERT;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] removed_value;
  logic [1:0]               status;
  logic [COUNT_W-1:0]       count;

  int          errors;
  int          outstanding;
  int          cycles = 0;
  int unsigned fill = 0;     // elements held once every sent transaction is applied
  bit          gaps_on = 1'b1;
  bit          quiet = 1'b0; // no idling on either side near the end

  positional_insert_delete_list_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .removed_value(removed_value), .status(status), .count(count)
  );

  list_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .removed_value(removed_value), .status(status), .count(count),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side stalls in bursts, with calm stretches in between.
  initial begin
    forever begin
      if (!quiet && $urandom_range(99, 0) < 30) begin
        repeat ($urandom_range(15, 1)) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(9, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1))
        @(posedge clk);
    end
  end

  task automatic put_op(input action_t op, input int unsigned pos,
                        input logic signed [DATA_W-1:0] val);
    in_valid <= 1'b1;
    action   <= op;
    position <= POS_W'(pos);
    value    <= val;
    do @(posedge clk); while (in_stall);
    if (op == ACT_INSERT) begin
      if (pos <= fill && fill < CAPACITY) fill++;
    end else if (pos >= 1 && pos <= fill) begin
      fill--;
    end
    if (gaps_on && !quiet && $urandom_range(99, 0) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  initial begin
    action_t                  op;
    int unsigned              pos;
    logic signed [DATA_W-1:0] val;
    int                       grow;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: deletes and an insert past the end are all out of range
    put_op(ACT_DELETE, 0, 32'sd5);
    put_op(ACT_DELETE, 1, 32'sd5);
    put_op(ACT_INSERT, 1, 32'sd9);
    put_op(ACT_INSERT, 0, 32'sh7fffffff);
    put_op(ACT_INSERT, 0, 32'sh80000000);  // front
    put_op(ACT_INSERT, 2, -32'sd1);        // back
    put_op(ACT_INSERT, 4, 32'sd3);         // beyond the end
    put_op(ACT_DELETE, 0, '0);
    put_op(ACT_DELETE, 4, '0);
    put_op(ACT_DELETE, 2, '0);             // middle
    put_op(ACT_DELETE, 2, '0);             // back
    put_op(ACT_INSERT, 1, 32'sd0);
    put_op(ACT_DELETE, 1, '0);             // front
    for (int k = 0; k < CAPACITY - 1; k++)
      put_op(ACT_INSERT, $urandom_range(fill, 0), $urandom);
    // full list: in-range inserts report full
    put_op(ACT_INSERT, 16, 32'sd1);
    put_op(ACT_INSERT, 0, 32'sd2);
    put_op(ACT_DELETE, 16, '0);

    grow = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 400) wait_drained();
      if (n == RANDOM_OPS - 150) quiet = 1'b1;
      if (n % 100 == 0) gaps_on = ($urandom_range(3, 0) != 0);
      if (n % 40 == 0) begin
        case ($urandom_range(2, 0))
          0: grow = 25;
          1: grow = 50;
          default: grow = 75;
        endcase
      end
      if (fill == CAPACITY) grow = 25;
      else if (fill == 0) grow = 75;

      op = ($urandom_range(99, 0) < grow) ? ACT_INSERT : ACT_DELETE;
      if ($urandom_range(99, 0) < 85) begin
        if (op == ACT_INSERT) pos = $urandom_range(fill, 0);
        else pos = (fill == 0) ? 0 : $urandom_range(fill, 1);
      end else begin
        pos = $urandom_range(16, 0);
      end
      case ($urandom_range(9, 0))
        0: val = 32'sh7fffffff;
        1: val = 32'sh80000000;
        2: val = '0;
        3: val = -32'sd1;
        default: val = $urandom;
      endcase
      put_op(op, pos, val);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pidl_pkg.sv
sv/pidl_cell.sv
sv/pidl_ctrl.sv
sv/positional_insert_delete_list_unit.sv
test/list_checker.sv
test/tb_top.sv
